[src/rrsd_pkg.sv]
// shared types and codes for the round-robin slice dispatcher
// no dependencies; imported by the cell, the top level and the checker
package rrsd_pkg;

   localparam int ID_WIDTH   = 22;
   localparam int BURST_WIDTH = 16;
   localparam int QUANT_WIDTH = 16;
   localparam int COUNT_WIDTH = 7;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_STEP  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_LOADED  = 3'd0,
      ST_SLICE   = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_FULL    = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]             op;
      logic [ID_WIDTH-1:0]    job_id;
      logic [BURST_WIDTH-1:0] burst_len;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic [ID_WIDTH-1:0]    ran_id;
      logic [BURST_WIDTH-1:0] slice_time;
      logic [BURST_WIDTH-1:0] time_left;
      logic                   retired;
      logic [COUNT_WIDTH-1:0] jobs_waiting;
   } rsp_type;

   // per-cell control: shift toward the head, or take the write data
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

[src/rrsd_cell.sv]
// one slot of the ready queue: holds a job and takes its neighbor's job on a shift
// depends on rrsd_pkg
module rrsd_cell import rrsd_pkg::*; #(
   parameter int DATA_WIDTH = 38
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] load_data,
   input  logic [DATA_WIDTH-1:0] next_data,
   output logic [DATA_WIDTH-1:0] data
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // a write wins over the shift so the requeued job lands at the new tail
   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[src/round_robin_slice_dispatcher_unit.sv]
// round-robin time-slice dispatcher top level: control, occupancy and the cell row
// depends on rrsd_pkg and rrsd_cell
//
//   channel   ports                          direction   handshake
//   request   start, busy, req_payload       in          start & !busy
//   response  rsp_strobe, rsp_payload        out         one-cycle strobe
//   csr       csr_wr_en, csr_wr_data         in          write on csr_wr_en
//
// each accepted request is registered into req_ff; from req_ff the cell row is
// updated and the response is registered, shown for one cycle.
// busy is high for the one cycle between; the head job is always cell 0.
// reset clears occupancy, busy and strobe and sets the quantum to 4;
// cell contents are not cleared. the response side never stalls.
module round_robin_slice_dispatcher_unit import rrsd_pkg::*; #(
   parameter int QUEUE_DEPTH = 64,
   parameter int TIME_WIDTH  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_payload,
   output logic                   rsp_strobe,
   output rsp_type                rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [QUANT_WIDTH-1:0] csr_wr_data
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W = ID_WIDTH + TIME_WIDTH;
   localparam int CMP_W  = (TIME_WIDTH > QUANT_WIDTH) ? TIME_WIDTH : QUANT_WIDTH;

   logic                   busy_ff, busy_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_ff, rsp_in;
   req_type                req_ff, req_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [QUANT_WIDTH-1:0] quantum_ff, quantum_in;

   logic [DATA_W-1:0]      cell_data [QUEUE_DEPTH];
   logic [DATA_W-1:0]      wr_data;
   logic                   wr_en;
   logic                   shift_en;
   logic [SLOT_W-1:0]      wr_slot;
   logic [ID_WIDTH-1:0]    head_id;
   logic [TIME_WIDTH-1:0]  head_time;
   logic [CMP_W-1:0]       run_ext;
   logic [TIME_WIDTH-1:0]  rem_after;
   logic [OCC_W-1:0]       occ_m1;
   logic                   accept;

   assign accept    = start && !busy_ff;
   assign head_id   = cell_data[0][DATA_W-1:TIME_WIDTH];
   assign head_time = cell_data[0][TIME_WIDTH-1:0];
   assign occ_m1    = occ_ff - OCC_W'(1);

   // slice length is min(quantum, remaining)
   always_comb begin
      if (CMP_W'(quantum_ff) < CMP_W'(head_time)) begin
         run_ext = CMP_W'(quantum_ff);
      end else begin
         run_ext = CMP_W'(head_time);
      end
      rem_after = head_time - TIME_WIDTH'(run_ext);
   end

   // control, queue update and response
   always_comb begin
      busy_in       = busy_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      req_in        = req_ff;
      occ_in        = occ_ff;
      quantum_in    = quantum_ff;
      wr_en         = 1'b0;
      shift_en      = 1'b0;
      wr_slot       = occ_ff[SLOT_W-1:0];
      wr_data       = {req_ff.job_id, TIME_WIDTH'(req_ff.burst_len)};

      if (csr_wr_en) begin
         quantum_in = csr_wr_data;
      end

      if (accept) begin
         req_in  = req_payload;
         busy_in = 1'b1;
      end

      if (busy_ff) begin
         busy_in             = 1'b0;
         rsp_strobe_in       = 1'b1;
         rsp_in.ran_id       = '0;
         rsp_in.slice_time   = '0;
         rsp_in.time_left    = '0;
         rsp_in.retired      = 1'b0;
         case (req_ff.op)
            OP_LOAD: begin
               if (occ_ff == OCC_W'(QUEUE_DEPTH)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  occ_in        = occ_ff + OCC_W'(1);
                  rsp_in.status = ST_LOADED;
               end
            end
            OP_STEP: begin
               if (occ_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  shift_en          = 1'b1;
                  rsp_in.status     = ST_SLICE;
                  rsp_in.ran_id     = head_id;
                  rsp_in.slice_time = BURST_WIDTH'(run_ext);
                  rsp_in.time_left  = BURST_WIDTH'(rem_after);
                  wr_data           = {head_id, rem_after};
                  wr_slot           = occ_m1[SLOT_W-1:0];
                  if (rem_after != '0) begin
                     wr_en = 1'b1;
                  end else begin
                     rsp_in.retired = 1'b1;
                     occ_in         = occ_m1;
                  end
               end
            end
            default: begin
               // clear, including the unused fourth op code
               occ_in        = '0;
               rsp_in.status = ST_CLEARED;
            end
         endcase
         rsp_in.jobs_waiting = COUNT_WIDTH'(occ_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         occ_ff        <= '0;
         quantum_ff    <= QUANT_WIDTH'(4);
      end else begin
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
         occ_ff        <= occ_in;
         quantum_ff    <= quantum_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // cell 0 is the head; a shift moves each job down, the last cell takes wr_data
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [DATA_W-1:0] next_data;

      assign ctrl.shift = shift_en;
      assign ctrl.load  = wr_en && (wr_slot == SLOT_W'(i));

      if (i < QUEUE_DEPTH - 1) begin : g_mid
         assign next_data = cell_data[i+1];
      end else begin : g_last
         assign next_data = wr_data;
      end

      rrsd_cell #(
         .DATA_WIDTH(DATA_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_data (wr_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

[src/rrsd_checker.sv]
// port-level checks for the round-robin slice dispatcher, bound to the top level
// depends on rrsd_pkg and round_robin_slice_dispatcher_unit
module rrsd_port_checker import rrsd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input rsp_type                rsp_payload
);

   // an accepted request keeps the block busy for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // every busy cycle ends in exactly one response strobe
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe && !busy)
      else $error("busy cycle not followed by a response");

   // a retired job is a slice with no time left
   a_retired: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.retired |->
         rsp_payload.status == ST_SLICE && rsp_payload.time_left == '0)
      else $error("retired job with time left");

   // only a slice carries job fields
   a_no_slice: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status != ST_SLICE |->
         rsp_payload.ran_id == '0 && rsp_payload.slice_time == '0 &&
         rsp_payload.time_left == '0)
      else $error("job fields set on a response without a slice");

   // a clear leaves the queue empty
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status == ST_CLEARED |->
         rsp_payload.jobs_waiting == '0)
      else $error("queue not empty after clear");

endmodule

bind round_robin_slice_dispatcher_unit rrsd_port_checker u_rrsd_port_checker (.*);

[tb/rrsd_checker.sv]
// checker for the round-robin slice dispatcher: watches the request, response and csr ports
// keeps its own model of the ready queue and compares every response field by field
// depends on rrsd_pkg
module rrsd_checker import rrsd_pkg::*; #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  req_type                req_payload,
   input  logic                   rsp_strobe,
   input  rsp_type                rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [QUANT_WIDTH-1:0] csr_wr_data,
   output int                     mismatch_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [QUANT_WIDTH-1:0] RESET_QUANTUM = 16'd4;

   typedef struct {
      logic [ID_WIDTH-1:0]    id;
      logic [BURST_WIDTH-1:0] remaining;
   } job_type;

   job_type                ready_jobs[$];
   rsp_type                expected_rsp[$];
   logic [QUANT_WIDTH-1:0] quantum;

   // apply one request to the ready queue and return the response it should give
   function automatic rsp_type dispatch(input req_type req);
      rsp_type                r;
      job_type                job;
      logic [BURST_WIDTH-1:0] run;
      r = '0;
      if (req.op[1]) begin
         // op 3 decodes as clear as well
         ready_jobs.delete();
         r.status = ST_CLEARED;
      end else if (req.op == OP_LOAD) begin
         if (ready_jobs.size() >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            job.id        = req.job_id;
            job.remaining = req.burst_len;
            ready_jobs.insert(ready_jobs.size(), job);
            r.status = ST_LOADED;
         end
      end else if (ready_jobs.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         job = ready_jobs.pop_front();
         run = (quantum < job.remaining) ? quantum : job.remaining;
         job.remaining -= run;
         r.status     = ST_SLICE;
         r.ran_id     = job.id;
         r.slice_time = run;
         r.time_left  = job.remaining;
         if (job.remaining != 0) begin
            ready_jobs.insert(ready_jobs.size(), job);
         end else begin
            r.retired = 1'b1;
         end
      end
      r.jobs_waiting = COUNT_WIDTH'(ready_jobs.size());
      return r;
   endfunction

   task automatic flag_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ready_jobs.delete();
         expected_rsp.delete();
         quantum = RESET_QUANTUM;
      end else begin
         if (csr_wr_en) begin
            quantum = csr_wr_data;
         end
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with no request pending, expected none, actual %h",
                        $realtime, rsp_payload);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload.status !== want.status)
                  flag_field("status", 32'(want.status), 32'(rsp_payload.status));
               if (rsp_payload.ran_id !== want.ran_id)
                  flag_field("ran_id", 32'(want.ran_id), 32'(rsp_payload.ran_id));
               if (rsp_payload.slice_time !== want.slice_time)
                  flag_field("slice_time", 32'(want.slice_time),
                             32'(rsp_payload.slice_time));
               if (rsp_payload.time_left !== want.time_left)
                  flag_field("time_left", 32'(want.time_left), 32'(rsp_payload.time_left));
               if (rsp_payload.retired !== want.retired)
                  flag_field("retired", 32'(want.retired), 32'(rsp_payload.retired));
               if (rsp_payload.jobs_waiting !== want.jobs_waiting)
                  flag_field("jobs_waiting", 32'(want.jobs_waiting),
                             32'(rsp_payload.jobs_waiting));
            end
         end
         if (start && !busy) begin
            expected_rsp.insert(expected_rsp.size(), dispatch(req_payload));
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

[tb/tb.sv]
// testbench top for round_robin_slice_dispatcher_unit: clock, reset, request stimulus,
// quantum phases, watchdog and verdict; checking is done by rrsd_checker
// depends on rrsd_pkg, rrsd_checker and the dispatcher rtl
module tb import rrsd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH    = 64;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_ITEMS    = 70;

   // op 3 is not in the enum but the block decodes it as clear
   localparam logic [1:0] OP_CLEAR_ALT = 2'd3;

   localparam logic [ID_WIDTH-1:0]    ID_MAX    = '1;
   localparam logic [BURST_WIDTH-1:0] BURST_MAX = '1;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} mode_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_payload;
   logic                   rsp_strobe;
   rsp_type                rsp_payload;
   logic                   csr_wr_en;
   logic [QUANT_WIDTH-1:0] csr_wr_data;

   int                     mismatch_count;
   int                     pending_count;
   int                     idle_cycles;
   logic [QUANT_WIDTH-1:0] quantum_now;

   round_robin_slice_dispatcher_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TIME_WIDTH (BURST_WIDTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   rrsd_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_strobe    (rsp_strobe),
      .rsp_payload   (rsp_payload),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // any accepted request or response restarts the count
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // entered and left at a falling edge; busy is stable there
   task automatic send_request(input logic [1:0] op, input logic [ID_WIDTH-1:0] id,
                               input logic [BURST_WIDTH-1:0] burst);
      req_type req;
      req.op        = op;
      req.job_id    = id;
      req.burst_len = burst;
      start       <= 1'b1;
      req_payload <= req;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_quantum(input logic [QUANT_WIDTH-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      quantum_now = value;
   endtask

   function automatic logic [BURST_WIDTH-1:0] pick_burst();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return BURST_WIDTH'($urandom_range(0, 20));
      // near the quantum, wrapping at the extremes
      if (roll < 60) return BURST_WIDTH'(quantum_now + $urandom_range(0, 2) - 1);
      if (roll < 70) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return BURST_WIDTH'(1);
            2:       return BURST_MAX - BURST_WIDTH'(1);
            default: return BURST_MAX;
         endcase
      end
      return BURST_WIDTH'($urandom);
   endfunction

   task automatic random_item(input int load_pct, input int step_pct);
      int         roll;
      logic [1:0] op;
      roll = $urandom_range(0, 99);
      if (roll < load_pct) op = OP_LOAD;
      else if (roll < load_pct + step_pct) op = OP_STEP;
      else op = ($urandom_range(0, 1) != 0) ? OP_CLEAR : OP_CLEAR_ALT;
      send_request(op, ID_WIDTH'($urandom), pick_burst());
   endtask

   task automatic random_gap(input bit no_idle);
      int roll;
      roll = $urandom_range(0, 99);
      if (!no_idle && roll >= 65) begin
         start <= 1'b0;
         if (roll < 95) repeat ($urandom_range(1, 3)) @(negedge clock);
         else repeat ($urandom_range(10, 40)) @(negedge clock);
      end else if (roll < 2) begin
         wait_drained();
      end
   endtask

   initial begin
      logic [QUANT_WIDTH-1:0] quanta [PHASE_COUNT];
      mode_type               mode;
      int                     done;
      int                     len;
      bit                     no_idle;

      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      quantum_now = 16'd4;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset quantum
      send_request(OP_STEP, ID_MAX, BURST_MAX);       // empty queue
      send_request(OP_LOAD, '0, '0);                  // zero burst
      send_request(OP_LOAD, ID_MAX, BURST_MAX);
      send_request(OP_LOAD, 22'h155555, 16'd5);
      send_request(OP_LOAD, 22'h2AAAAA, 16'd4);       // exactly one quantum
      send_request(OP_STEP, '0, '0);                  // zero burst runs 0 and retires
      send_request(OP_STEP, '0, '0);
      start <= 1'b0;
      repeat (3) @(negedge clock);
      send_request(OP_STEP, '0, '0);
      send_request(OP_STEP, '0, '0);
      send_request(OP_STEP, '0, '0);
      send_request(OP_STEP, '0, '0);                  // last unit of the 5 burst
      send_request(OP_CLEAR, ID_MAX, BURST_MAX);
      send_request(OP_STEP, '0, '0);
      send_request(OP_LOAD, 22'h0F0F0F, 16'h8000);
      send_request(OP_LOAD, 22'h30F0F0, 16'h7FFF);
      send_request(OP_CLEAR_ALT, '0, '0);
      send_request(OP_STEP, '0, '0);
      send_request(OP_LOAD, 22'h000001, 16'd1);
      send_request(OP_STEP, '0, '0);

      quanta = '{16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd4, 16'd4};
      quanta[4] = QUANT_WIDTH'($urandom_range(5, 300));

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_quantum(quanta[phase]);
         done = 0;
         if (phase == 0) begin
            // fill well past the queue depth to reach the full rejects
            send_request(OP_CLEAR, ID_WIDTH'($urandom), BURST_WIDTH'($urandom));
            for (int i = 0; i < 75; i++) begin
               random_item(95, 5);
               random_gap(1'b0);
            end
            done = 75;
         end
         while (done < PHASE_ITEMS) begin
            len     = $urandom_range(10, 40);
            mode    = mode_type'($urandom_range(0, 2));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
               case (mode)
                  MODE_FILL:  random_item(85, 13);
                  MODE_DRAIN: random_item(15, 83);
                  default:    random_item(50, 45);
               endcase
               random_gap(no_idle);
               done++;
            end
         end
      end

      wait_drained();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
src/rrsd_pkg.sv
src/rrsd_cell.sv
src/round_robin_slice_dispatcher_unit.sv
src/rrsd_checker.sv
tb/rrsd_checker.sv
tb/tb.sv
